// ----- hw/rtl/hbd_pkg.sv -----
// shared types and constants of the heartbeat bpm detector
package hbd_pkg;

  localparam int LEVEL_W    = 14;
  localparam int TIME_W     = 16;
  localparam int DROP_W     = 14;
  localparam int BEATS_W    = 3;
  localparam int TRK_W      = 15;
  localparam int BPM_W      = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_LOSS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_DROP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BEATS_REQ   = 2'd3;

  // register defaults
  localparam logic [TIME_W-1:0]  REFRACTORY_RST  = 16'd250;
  localparam logic [TIME_W-1:0]  SIGNAL_LOSS_RST = 16'd2000;
  localparam logic [DROP_W-1:0]  LOW_DROP_RST    = 14'd70;
  localparam logic [BEATS_W-1:0] BEATS_REQ_RST   = 3'd5;

  // window start values
  localparam logic [TRK_W-1:0]   PEAK_INIT   = 15'd2500;
  localparam logic [TRK_W-1:0]   TROUGH_INIT = 15'd1500;
  localparam logic [TRK_W-1:0]   LOWER_INIT  = 15'd50;
  localparam logic [TRK_W-1:0]   UPPER_INIT  = 15'd60;
  localparam logic [TIME_W-1:0]  PREV_INIT   = 16'd1000;
  localparam logic [BPM_W-1:0]   BPM_RST     = 8'd60;
  localparam logic [BPM_W-1:0]   BPM_MAX     = 8'd255;

  localparam int BPM_SCALE_MS = 60000;

  typedef struct packed {
    logic load;
    logic track;
    logic finish;
    logic div_step;
    logic out_load;
  } hbd_cmd_t;

  typedef struct packed {
    logic started;
    logic div_last;
  } hbd_status_t;

endpackage

// ----- hw/rtl/heartbeat_bpm_detector.sv -----
// top level of the heartbeat bpm detector
// an accepted item is latched, tracked and finished; on a beat start the restoring bpm
//   divider then runs Q = clog2(60000 * HISTORY_DEPTH + 1) steps (20 at depth 10); the
//   result is then loaded into the output registers once no earlier result is stalled;
//   no new item is taken before that load; the divider retires one quotient bit per cycle
// reset: synchronous, active low; registers and window state return to defaults
module heartbeat_bpm_detector
  import hbd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LEVEL_W-1:0]    in_level,
  input  logic [TIME_W-1:0]     in_time_ms,
  input  logic                  in_new_window,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BPM_W-1:0]      out_bpm,
  output logic                  out_bpm_valid,
  output logic                  out_beat_start
);

  hbd_cmd_t    cmd;
  hbd_status_t status;

  hbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .status    (status)
  );

  hbd_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_level       (in_level),
    .in_time_ms     (in_time_ms),
    .in_new_window  (in_new_window),
    .cmd            (cmd),
    .status         (status),
    .out_bpm        (out_bpm),
    .out_bpm_valid  (out_bpm_valid),
    .out_beat_start (out_beat_start)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while previous item in progress");

  a_div_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && status.div_last) |=> !cmd.div_step)
    else $error("divider stepped past last quotient bit");

endmodule

// ----- hw/rtl/hbd_ctrl.sv -----
// sequencing state machine of the heartbeat bpm detector
module hbd_ctrl
  import hbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        out_stall,
  output logic        out_valid,
  output hbd_cmd_t    cmd,
  input  hbd_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRACK,
    S_FINISH,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_TRACK;
        end
      end
      S_TRACK: begin
        cmd.track = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = status.started ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/hbd_dp.sv -----
// datapath: thresholds, beat tracking, interval history and serial bpm divider
module hbd_dp
  import hbd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [LEVEL_W-1:0]    in_level,
  input  logic [TIME_W-1:0]     in_time_ms,
  input  logic                  in_new_window,
  input  hbd_cmd_t              cmd,
  output hbd_status_t           status,
  output logic [BPM_W-1:0]      out_bpm,
  output logic                  out_bpm_valid,
  output logic                  out_beat_start
);

  localparam int SUM_W    = $clog2(HISTORY_DEPTH * ((1 << TIME_W) - 1) + 1);
  localparam int DIVIDEND = BPM_SCALE_MS * HISTORY_DEPTH;
  localparam int QUO_W    = $clog2(DIVIDEND + 1);
  localparam int CNT_W    = $clog2(QUO_W);

  // configuration
  logic [TIME_W-1:0]  refr_r, sigloss_r;
  logic [DROP_W-1:0]  drop_r;
  logic [BEATS_W-1:0] beats_req_r;

  // latched item
  logic [LEVEL_W-1:0] level_r;
  logic [TIME_W-1:0]  time_r;

  // window state
  logic [TRK_W-1:0]   peak_r, trough_r, lower_r, upper_r;
  logic               in_beat_r, awaiting_r, found_r;
  logic [TIME_W-1:0]  last_beat_r, prev_r;
  logic [BEATS_W-1:0] beat_cnt_r;
  logic [BPM_W-1:0]   bpm_r;
  logic [TIME_W-1:0]  hist_r [HISTORY_DEPTH];
  logic [SUM_W-1:0]   sum_r;

  logic [TIME_W-1:0]  interval_r;
  logic               started_r;

  // divider
  logic [SUM_W-1:0]   rem_r;
  logic [QUO_W-1:0]   quo_r;
  logic [CNT_W-1:0]   cnt_r;

  logic [BPM_W-1:0]   out_bpm_r;
  logic               out_bpm_valid_r, out_beat_start_r;

  logic [TRK_W-1:0]   lvl_ext;
  logic [TIME_W-1:0]  interval;
  logic [TIME_W+2:0]  int_x5, prev_x3;
  logic               trough_hit, peak_hit, beat_hit, end_hit;
  logic [BEATS_W-1:0] beat_cnt_inc;
  logic [TRK_W-1:0]   lower_start;
  logic [SUM_W-1:0]   sum_nxt;
  logic [TRK_W:0]     mid_sum;
  logic [SUM_W:0]     trial, trial_sub;
  logic               fits;
  logic [SUM_W-1:0]   rem_nxt;
  logic [QUO_W-1:0]   quo_nxt;
  logic [BPM_W-1:0]   bpm_sat;

  assign lvl_ext      = {1'b0, level_r};
  assign interval     = time_r - last_beat_r;
  assign int_x5       = {3'b000, interval} + {1'b0, interval, 2'b00};
  assign prev_x3      = {3'b000, prev_r} + {2'b00, prev_r, 1'b0};
  assign trough_hit   = (lvl_ext < lower_r) && (int_x5 > prev_x3) && (lvl_ext < trough_r);
  assign peak_hit     = (lvl_ext > upper_r) && (lvl_ext > peak_r);
  assign beat_hit     = (interval > refr_r) && (lvl_ext > upper_r) && !in_beat_r;
  assign beat_cnt_inc = beat_cnt_r + 3'd1;
  assign lower_start  = (level_r > drop_r) ? TRK_W'(level_r - drop_r) : '0;

  always_comb begin
    if (awaiting_r) begin
      sum_nxt = SUM_W'(interval) * SUM_W'(HISTORY_DEPTH);
    end else begin
      sum_nxt = sum_r - SUM_W'(hist_r[0]) + SUM_W'(interval);
    end
  end

  assign end_hit = ((lvl_ext < lower_r) && in_beat_r) || (interval_r > sigloss_r);
  assign mid_sum = {1'b0, peak_r} + {1'b0, trough_r};

  // restoring division, one quotient bit per step
  assign trial     = {rem_r, quo_r[QUO_W-1]};
  assign fits      = (trial >= {1'b0, sum_r});
  assign trial_sub = trial - {1'b0, sum_r};
  assign rem_nxt   = fits ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
  assign quo_nxt   = {quo_r[QUO_W-2:0], fits};
  assign bpm_sat   = (|quo_nxt[QUO_W-1:BPM_W]) ? BPM_MAX : quo_nxt[BPM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refr_r      <= REFRACTORY_RST;
      sigloss_r   <= SIGNAL_LOSS_RST;
      drop_r      <= LOW_DROP_RST;
      beats_req_r <= BEATS_REQ_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REFRACTORY:  refr_r      <= cfg_wdata[TIME_W-1:0];
        CFG_SIGNAL_LOSS: sigloss_r   <= cfg_wdata[TIME_W-1:0];
        CFG_LOW_DROP:    drop_r      <= cfg_wdata[DROP_W-1:0];
        CFG_BEATS_REQ:   beats_req_r <= cfg_wdata[BEATS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.load && in_new_window)) begin
      peak_r      <= PEAK_INIT;
      trough_r    <= TROUGH_INIT;
      lower_r     <= LOWER_INIT;
      upper_r     <= UPPER_INIT;
      in_beat_r   <= 1'b0;
      awaiting_r  <= 1'b1;
      last_beat_r <= '0;
      prev_r      <= PREV_INIT;
      beat_cnt_r  <= '0;
      found_r     <= 1'b0;
    end else if (cmd.track) begin
      if (trough_hit) begin
        trough_r <= lvl_ext;
      end
      if (peak_hit) begin
        peak_r <= lvl_ext;
      end
      if (beat_hit) begin
        in_beat_r   <= 1'b1;
        awaiting_r  <= 1'b0;
        lower_r     <= lower_start;
        prev_r      <= interval;
        last_beat_r <= time_r;
        if (beat_cnt_inc == beats_req_r) begin
          found_r    <= 1'b1;
          beat_cnt_r <= '0;
        end else begin
          beat_cnt_r <= beat_cnt_inc;
        end
      end
    end else if (cmd.finish && end_hit) begin
      in_beat_r <= 1'b0;
      upper_r   <= mid_sum[TRK_W:1];
      peak_r    <= mid_sum[TRK_W:1];
      trough_r  <= lower_r;
    end
  end

  // bpm survives a new window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpm_r <= BPM_RST;
    end else if (cmd.div_step && status.div_last) begin
      bpm_r <= bpm_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      level_r <= in_level;
      time_r  <= in_time_ms;
    end
    if (cmd.track) begin
      interval_r <= interval;
      started_r  <= beat_hit;
      if (beat_hit) begin
        for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
          hist_r[i] <= awaiting_r ? interval : hist_r[i+1];
        end
        hist_r[HISTORY_DEPTH-1] <= interval;
        sum_r                   <= sum_nxt;
      end
    end
    if (cmd.finish) begin
      rem_r <= '0;
      quo_r <= QUO_W'(DIVIDEND);
      cnt_r <= CNT_W'(QUO_W - 1);
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.out_load) begin
      out_bpm_r        <= bpm_r;
      out_bpm_valid_r  <= found_r;
      out_beat_start_r <= started_r;
    end
  end

  assign status.started  = started_r;
  assign status.div_last = (cnt_r == '0);

  assign out_bpm        = out_bpm_r;
  assign out_bpm_valid  = out_bpm_valid_r;
  assign out_beat_start = out_beat_start_r;

endmodule

// ----- verif/tb.sv -----
// self-checking testbench of the heartbeat bpm detector: random sensor traces against a predictor
`timescale 1ns / 100ps

module tb;
  import hbd_pkg::*;

  localparam int HIST_DEPTH = 10;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  time_ms;
    logic               new_window;
  } sample_t;

  typedef struct packed {
    logic [BPM_W-1:0] bpm;
    logic             bpm_valid;
    logic             beat_start;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_REFRACTORY;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [LEVEL_W-1:0]    in_level = '0;
  logic [TIME_W-1:0]     in_time_ms = '0;
  logic                  in_new_window = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BPM_W-1:0]      out_bpm;
  logic                  out_bpm_valid;
  logic                  out_beat_start;

  heartbeat_bpm_detector #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_level      (in_level),
    .in_time_ms    (in_time_ms),
    .in_new_window (in_new_window),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_bpm       (out_bpm),
    .out_bpm_valid (out_bpm_valid),
    .out_beat_start(out_beat_start)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor copy of registers and window state
  logic [TIME_W-1:0]  refr_cfg, loss_cfg;
  logic [DROP_W-1:0]  drop_cfg;
  logic [BEATS_W-1:0] req_cfg;
  logic [TRK_W-1:0]   peak_q, trough_q, lower_q, upper_q;
  logic               in_beat_q, first_beat_q, found_q;
  logic [TIME_W-1:0]  last_beat_q, prev_ivl_q;
  logic [TIME_W-1:0]  ivl_hist [HIST_DEPTH];
  logic [BEATS_W-1:0] beat_cnt_q;
  logic [BPM_W-1:0]   bpm_q;

  sample_t  samples_todo [$];
  reading_t readings_due [$];
  sample_t  cur_sample;
  reading_t next_reading;
  reading_t got_reading;
  logic [TIME_W-1:0] wave_ms = '0;

  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  bit          took;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  int unsigned idle_run = 0;
  int unsigned mismatches = 0;
  int unsigned samples_sent = 0;
  int unsigned readings_seen = 0;
  int unsigned beats_seen = 0;
  int unsigned valid_seen = 0;
  int unsigned windows_seen = 0;
  int unsigned settings_run = 1;

  function automatic void window_clear();
    peak_q       = PEAK_INIT;
    trough_q     = TROUGH_INIT;
    lower_q      = LOWER_INIT;
    upper_q      = UPPER_INIT;
    in_beat_q    = 1'b0;
    first_beat_q = 1'b1;
    last_beat_q  = '0;
    prev_ivl_q   = PREV_INIT;
    for (int i = 0; i < HIST_DEPTH; i++) ivl_hist[i] = '0;
    beat_cnt_q   = '0;
    found_q      = 1'b0;
  endfunction

  function automatic void restore_defaults();
    refr_cfg = REFRACTORY_RST;
    loss_cfg = SIGNAL_LOSS_RST;
    drop_cfg = LOW_DROP_RST;
    req_cfg  = BEATS_REQ_RST;
    window_clear();
    bpm_q = BPM_RST;
  endfunction

  function automatic reading_t track_sample(sample_t s);
    logic [TIME_W-1:0] ivl;
    int unsigned hist_sum, quot;
    reading_t r;
    if (s.new_window) window_clear();
    ivl = s.time_ms - last_beat_q;
    r.beat_start = 1'b0;
    if (s.level < lower_q && 32'(ivl) * 5 > 32'(prev_ivl_q) * 3 && s.level < trough_q)
      trough_q = TRK_W'(s.level);
    if (s.level > upper_q && s.level > peak_q) peak_q = TRK_W'(s.level);
    if (ivl > refr_cfg && s.level > upper_q && !in_beat_q) begin
      r.beat_start = 1'b1;
      in_beat_q    = 1'b1;
      beat_cnt_q   = beat_cnt_q + 1'b1;
      lower_q      = (s.level > drop_cfg) ? TRK_W'(s.level - drop_cfg) : '0;
      prev_ivl_q   = ivl;
      last_beat_q  = s.time_ms;
      // first beat of a window primes the whole history
      if (first_beat_q) begin
        first_beat_q = 1'b0;
        for (int i = 0; i < HIST_DEPTH; i++) ivl_hist[i] = ivl;
      end
      hist_sum = 0;
      for (int i = 0; i < HIST_DEPTH - 1; i++) begin
        ivl_hist[i] = ivl_hist[i+1];
        hist_sum += ivl_hist[i];
      end
      ivl_hist[HIST_DEPTH-1] = ivl;
      hist_sum += ivl;
      quot = (hist_sum == 0) ? 255 : (BPM_SCALE_MS * HIST_DEPTH) / hist_sum;
      bpm_q = (quot > 255) ? BPM_MAX : BPM_W'(quot);
      if (beat_cnt_q == req_cfg) begin
        found_q    = 1'b1;
        beat_cnt_q = '0;
      end
    end
    if ((s.level < lower_q && in_beat_q) || ivl > loss_cfg) begin
      in_beat_q = 1'b0;
      upper_q   = TRK_W'((32'(peak_q) + 32'(trough_q)) >> 1);
      peak_q    = upper_q;
      trough_q  = lower_q;
    end
    r.bpm       = bpm_q;
    r.bpm_valid = found_q;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(string what);
    $display("reading %0d: %s", readings_seen, what);
    mismatches++;
  endtask

  // sample driver
  always @(posedge clk) begin
    took = in_valid && !in_stall;
    if (took) begin
      next_reading = track_sample(cur_sample);
      readings_due.push_back(next_reading);
      samples_sent++;
      if (next_reading.beat_start) beats_seen++;
      if (next_reading.bpm_valid) valid_seen++;
      if (cur_sample.new_window) windows_seen++;
    end
    if (!in_valid || took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (samples_todo.size() > 0) begin
        cur_sample = samples_todo.pop_front();
        in_level      <= cur_sample.level;
        in_time_ms    <= cur_sample.time_ms;
        in_new_window <= cur_sample.new_window;
        in_valid      <= 1'b1;
        in_gap = in_idle_on ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // reading monitor
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (readings_due.size() == 0) begin
        flag_mismatch($sformatf("item with nothing expected, bpm %0d", out_bpm));
      end else begin
        got_reading = readings_due.pop_front();
        if (out_bpm !== got_reading.bpm)
          flag_mismatch($sformatf("bpm %0d, expected %0d", out_bpm, got_reading.bpm));
        if (out_bpm_valid !== got_reading.bpm_valid)
          flag_mismatch($sformatf("bpm_valid %0b, expected %0b", out_bpm_valid,
                                  got_reading.bpm_valid));
        if (out_beat_start !== got_reading.beat_start)
          flag_mismatch($sformatf("beat_start %0b, expected %0b", out_beat_start,
                                  got_reading.beat_start));
      end
      readings_seen++;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = out_idle_on ? pick_gap() : 0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run = 0;
    end else begin
      idle_run++;
      if (idle_run == IDLE_LIMIT) begin
        $display("timeout after %0d cycles without an item", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic add_sample(int unsigned lv, int unsigned t, bit nw);
    sample_t s;
    s.level      = LEVEL_W'(lv);
    s.time_ms    = TIME_W'(t);
    s.new_window = nw;
    samples_todo.push_back(s);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_REFRACTORY:  refr_cfg = val;
      CFG_SIGNAL_LOSS: loss_cfg = val;
      CFG_LOW_DROP:    drop_cfg = val[DROP_W-1:0];
      default:         req_cfg = val[BEATS_W-1:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(int unsigned refr, int unsigned loss, int unsigned drop,
                                int unsigned req);
    write_reg(CFG_REFRACTORY, CFG_DATA_W'(refr));
    write_reg(CFG_SIGNAL_LOSS, CFG_DATA_W'(loss));
    write_reg(CFG_LOW_DROP, CFG_DATA_W'(drop));
    write_reg(CFG_BEATS_REQ, CFG_DATA_W'(req));
    settings_run++;
  endtask

  // mostly pulse trains, with flat dropouts and noise with time jumps
  task automatic queue_random_samples(int unsigned n);
    int unsigned made, seg_len, kind, period, step, base, amp, ph, lv;
    sample_t s;
    made = 0;
    while (made < n) begin
      seg_len = $urandom_range(15, 70);
      kind    = $urandom_range(0, 99);
      period  = $urandom_range(300, 1500);
      step    = $urandom_range(4, 40);
      base    = $urandom_range(0, 2500);
      amp     = $urandom_range(800, 7500);
      ph      = $urandom_range(0, period - 1);
      for (int k = 0; k < seg_len && made < n; k++) begin
        s.new_window = (k == 0) && ($urandom_range(0, 7) == 0);
        if (kind < 72) begin
          lv = ((ph < period / 4) ? base + amp : base) + $urandom_range(0, 150);
          ph = (ph + step) % period;
          wave_ms = wave_ms + TIME_W'(step);
        end else if (kind < 85) begin
          lv = $urandom_range(0, 120);
          wave_ms = wave_ms + TIME_W'($urandom_range(20, 400));
        end else begin
          lv = $urandom_range(0, 16383);
          if ($urandom_range(0, 3) == 0) wave_ms = TIME_W'($urandom);
          else wave_ms = wave_ms + TIME_W'($urandom_range(0, 900));
        end
        s.level   = (lv > 16383) ? {LEVEL_W{1'b1}} : LEVEL_W'(lv);
        s.time_ms = wave_ms;
        samples_todo.push_back(s);
        made++;
      end
    end
  endtask

  task automatic drain();
    while (samples_todo.size() != 0 || in_valid || readings_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic finish_phase(int unsigned n);
    @(negedge clk);
    queue_random_samples(n);
    drain();
  endtask

  initial begin
    restore_defaults();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults straight out of reset
    @(negedge clk);
    add_sample(0, 0, 1'b1);
    add_sample(10000, 100, 1'b0);
    add_sample(16383, 300, 1'b0);
    add_sample(20, 400, 1'b0);
    add_sample(16383, 500, 1'b0);
    add_sample(9000, 700, 1'b0);
    add_sample(0, 3000, 1'b0);
    add_sample(5000, 65535, 1'b0);
    add_sample(5000, 100, 1'b0);
    add_sample(12000, 50, 1'b0);
    add_sample(0, 65535, 1'b1);
    add_sample(10000, 65535, 1'b0);
    add_sample(30, 65535, 1'b0);
    finish_phase(240);

    // no refractory, no timeout, threshold drop saturating at zero
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    apply_settings(0, 16'hFFFF, 16'h3FFF, 7);
    @(negedge clk);
    add_sample(16383, 1, 1'b1);
    add_sample(0, 2, 1'b0);
    add_sample(16383, 3, 1'b0);
    add_sample(8000, 60000, 1'b0);
    finish_phase(150);

    in_idle_on = 1'b1;
    apply_settings(16'hFFFF, 0, 0, 1);
    finish_phase(60);

    in_idle_on  = 1'b0;
    out_idle_on = 1'b1;
    apply_settings(300, 1500, 500, 0);
    finish_phase(250);

    in_idle_on = 1'b1;
    apply_settings(200, 3000, 70, 3);
    finish_phase(250);

    apply_settings($urandom_range(100, 400), $urandom_range(800, 4000),
                   $urandom_range(0, 2000), $urandom_range(1, 7));
    finish_phase(320);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (readings_due.size() != 0)
      flag_mismatch($sformatf("%0d expected items never came", readings_due.size()));
    $display("run: %0d samples under %0d register settings, %0d opening a new window",
             samples_sent, settings_run, windows_seen);
    $display("run: %0d beat starts predicted, %0d items with bpm valid",
             beats_seen, valid_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
